// ===== hdl/date_difference_days_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Date difference unit assertion macros
// Property wrappers for the unit's assertions, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef DATE_DIFFERENCE_DAYS_UNIT_ASSERT_SVH
`define DATE_DIFFERENCE_DAYS_UNIT_ASSERT_SVH

// same-cycle implication
`define DDU_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("date difference unit: assertion failed");

// next-cycle implication
`define DDU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("date difference unit: assertion failed");

`endif

// ===== hdl/ddu_pkg.sv =====
// ----------------------------------------------------------------------------
// Date difference unit package
// Field widths, calendar constants and month tables.
// ----------------------------------------------------------------------------
package ddu_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 23;
   localparam int DNUM_W  = 23;
   localparam int Y4_W    = 12;
   localparam int Q25_W   = 8;
   localparam int PROD_W  = 25;
   localparam int BC_W    = 13;
   localparam int MOFF_W  = 9;
   localparam int YCMP_W  = 17;

   // x / 25 == (x * 5243) >> 17 for x < 4096
   localparam logic [12:0] DIV25_MUL = 13'd5243;
   localparam logic [Y4_W-1:0] Y4_PER_CENTURY = 12'd25;
   localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [MONTH_W-1:0] MAR_SHIFT = 4'd3;
   localparam logic [MONTH_W-1:0] JAN_SHIFT = 4'd9;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   // days before month, March-based month index
   function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] mp);
      logic [MOFF_W-1:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // length of a common-year month, zero for a bad month
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] r;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
         4'd2:                                       r = 5'd28;
         default:                                    r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/ddu_day_number.sv =====
// ----------------------------------------------------------------------------
// Day number pipeline
// Three-stage check and Gregorian day number of one date (1 March, year 0).
// ----------------------------------------------------------------------------
module ddu_day_number #(
   parameter int YEAR_MAX = 9999
) (
   input  logic                              clock,
   input  ddu_pkg::stage_en_type             en,
   input  logic [ddu_pkg::YEAR_W-1:0]        year,
   input  logic [ddu_pkg::MONTH_W-1:0]       month,
   input  logic [ddu_pkg::DAY_W-1:0]         day,
   output logic                              date_ok,
   output logic [ddu_pkg::DNUM_W-1:0]        day_num
);

   // stage 1: range checks, shifted year, quotients by 100
   logic                            m_ok_in, m_ok_ff;
   logic                            y_ok_in, y_ok_ff;
   logic                            y4z_in, y4z_ff;
   logic [ddu_pkg::Y4_W-1:0]        y4_in, y4_ff;
   logic [ddu_pkg::Q25_W-1:0]       qy_in, qy_ff;
   logic [ddu_pkg::YEAR_W-1:0]      yy_in, yy_ff;
   logic [ddu_pkg::Q25_W-1:0]       qyy_in, qyy_ff;
   logic [ddu_pkg::MONTH_W-1:0]     mp_in, mp_ff;
   logic [ddu_pkg::MONTH_W-1:0]     m_ff;
   logic [ddu_pkg::DAY_W-1:0]       d_ff;
   logic [ddu_pkg::PROD_W-1:0]      prod_y, prod_yy;

   always_comb begin
      m_ok_in = (month >= ddu_pkg::MONTH_JAN) && (month <= ddu_pkg::MONTH_DEC);
      y_ok_in = (year != '0) &&
                (ddu_pkg::YCMP_W'(year) <= ddu_pkg::YCMP_W'(YEAR_MAX));
      y4z_in  = (year[1:0] == 2'b00);
      y4_in   = year[ddu_pkg::YEAR_W-1:2];
      yy_in   = (month <= ddu_pkg::MONTH_FEB) ? year - ddu_pkg::YEAR_W'(1) : year;
      mp_in   = (month >= ddu_pkg::MONTH_MAR) ? month - ddu_pkg::MAR_SHIFT
                                              : month + ddu_pkg::JAN_SHIFT;
      prod_y  = ddu_pkg::PROD_W'(y4_in) * ddu_pkg::PROD_W'(ddu_pkg::DIV25_MUL);
      prod_yy = ddu_pkg::PROD_W'(yy_in[ddu_pkg::YEAR_W-1:2]) *
                ddu_pkg::PROD_W'(ddu_pkg::DIV25_MUL);
      qy_in   = prod_y[ddu_pkg::PROD_W-1 -: ddu_pkg::Q25_W];
      qyy_in  = prod_yy[ddu_pkg::PROD_W-1 -: ddu_pkg::Q25_W];
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         m_ok_ff <= m_ok_in;
         y_ok_ff <= y_ok_in;
         y4z_ff  <= y4z_in;
         y4_ff   <= y4_in;
         qy_ff   <= qy_in;
         yy_ff   <= yy_in;
         qyy_ff  <= qyy_in;
         mp_ff   <= mp_in;
         m_ff    <= month;
         d_ff    <= day;
      end
   end

   // stage 2: leap test, day check, year and month terms
   logic                            leap;
   logic [ddu_pkg::DAY_W-1:0]       len;
   logic                            ok2_in, ok2_ff;
   logic [ddu_pkg::DNUM_W-1:0]      a_in, a_ff;
   logic [ddu_pkg::BC_W-1:0]        bc_in, bc_ff;

   always_comb begin
      leap   = y4z_ff && ((y4_ff != ddu_pkg::Y4_W'(qy_ff) * ddu_pkg::Y4_PER_CENTURY) ||
                          (qy_ff[1:0] == 2'b00));
      len    = ddu_pkg::month_len(m_ff) +
               ddu_pkg::DAY_W'((m_ff == ddu_pkg::MONTH_FEB) && leap);
      ok2_in = m_ok_ff && y_ok_ff && (d_ff != '0) && (d_ff <= len);
      a_in   = ddu_pkg::DNUM_W'(yy_ff) * ddu_pkg::DNUM_W'(ddu_pkg::DAYS_PER_YEAR);
      bc_in  = ddu_pkg::BC_W'(yy_ff[ddu_pkg::YEAR_W-1:2]) - ddu_pkg::BC_W'(qyy_ff)
             + ddu_pkg::BC_W'(qyy_ff[ddu_pkg::Q25_W-1:2])
             + ddu_pkg::BC_W'(ddu_pkg::month_offset(mp_ff))
             + ddu_pkg::BC_W'(d_ff) - ddu_pkg::BC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         ok2_ff <= ok2_in;
         a_ff   <= a_in;
         bc_ff  <= bc_in;
      end
   end

   // stage 3: final sum
   logic                            ok3_ff;
   logic [ddu_pkg::DNUM_W-1:0]      dn_in, dn_ff;

   assign dn_in = a_ff + ddu_pkg::DNUM_W'(bc_ff);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         ok3_ff <= ok2_ff;
         dn_ff  <= dn_in;
      end
   end

   assign date_ok = ok3_ff;
   assign day_num = dn_ff;

endmodule

// ===== hdl/date_difference_days_unit.sv =====
// ----------------------------------------------------------------------------
// Date difference unit
// Signed count of days from a start date to an end date, Gregorian calendar.
// ----------------------------------------------------------------------------
// Takes one date pair per cycle while req_ready is high and returns day_count
// = day number of the end date minus day number of the start date, held in
// the stage 1 to 4 registers in turn. Three stages form each date's day
// number (checks and divide-by-100 reciprocal multiply, leap test with the
// 365x year multiply, final sum); the fourth subtracts, saturates to 23 bits
// and drives the output register. A month, day or year out of range in either
// date gives date_invalid = 1 and a count of zero. Each stage holds its word
// while the next is full, so up to four words are in flight under a stall.
module date_difference_days_unit #(
   parameter int YEAR_MAX = 9999
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ddu_pkg::YEAR_W-1:0]           req_start_year,
   input  logic [ddu_pkg::MONTH_W-1:0]          req_start_month,
   input  logic [ddu_pkg::DAY_W-1:0]            req_start_day,
   input  logic [ddu_pkg::YEAR_W-1:0]           req_end_year,
   input  logic [ddu_pkg::MONTH_W-1:0]          req_end_month,
   input  logic [ddu_pkg::DAY_W-1:0]            req_end_day,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ddu_pkg::COUNT_W-1:0]   rsp_day_count,
   output logic                                 rsp_date_invalid
);

   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   logic                   en4;
   ddu_pkg::stage_en_type  en;

   always_comb begin
      en4   = !v4_ff || rsp_ready;
      en.s3 = !v3_ff || en4;
      en.s2 = !v2_ff || en.s3;
      en.s1 = !v1_ff || en.s2;
   end

   assign req_ready = en.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff <= req_valid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
         if (en4)   v4_ff <= v3_ff;
      end
   end

   logic                          start_ok, end_ok;
   logic [ddu_pkg::DNUM_W-1:0]    start_dn, end_dn;

   ddu_day_number #(.YEAR_MAX(YEAR_MAX)) u_start (
      .clock   (clock),
      .en      (en),
      .year    (req_start_year),
      .month   (req_start_month),
      .day     (req_start_day),
      .date_ok (start_ok),
      .day_num (start_dn)
   );

   ddu_day_number #(.YEAR_MAX(YEAR_MAX)) u_end (
      .clock   (clock),
      .en      (en),
      .year    (req_end_year),
      .month   (req_end_month),
      .day     (req_end_day),
      .date_ok (end_ok),
      .day_num (end_dn)
   );

   // stage 4: subtract and saturate
   logic signed [ddu_pkg::DNUM_W:0]        diff;
   logic signed [ddu_pkg::COUNT_W-1:0]     count_in, count_ff;
   logic                                   invalid_in, invalid_ff;

   always_comb begin
      diff       = $signed({1'b0, end_dn}) - $signed({1'b0, start_dn});
      invalid_in = !(start_ok && end_ok);
      if (invalid_in) begin
         count_in = '0;
      end else if (diff[ddu_pkg::DNUM_W] != diff[ddu_pkg::COUNT_W-1]) begin
         count_in = {diff[ddu_pkg::DNUM_W], {(ddu_pkg::COUNT_W-1){!diff[ddu_pkg::DNUM_W]}}};
      end else begin
         count_in = diff[ddu_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         count_ff   <= count_in;
         invalid_ff <= invalid_in;
      end
   end

   assign rsp_valid        = v4_ff;
   assign rsp_day_count    = count_ff;
   assign rsp_date_invalid = invalid_ff;

`include "date_difference_days_unit_assert.svh"

   `DDU_ASSERT_IMPL(a_invalid_zero, rsp_valid && rsp_date_invalid, rsp_day_count == '0)
   `DDU_ASSERT_IMPL(a_empty_out_ready, !rsp_valid, req_ready)
   `DDU_ASSERT_IMPL(a_stall_full, !req_ready, rsp_valid && !rsp_ready)

endmodule
